// ----- rtl/ecenc_pkg.sv -----
package ecenc_pkg;

    localparam int MAX_EC = 32;
    localparam int IDX_W  = $clog2(MAX_EC);
    localparam int CNT_W  = $clog2(MAX_EC + 1);

    localparam logic [7:0] FIELD_LOW = 8'h1d;   // 0x11d with the x^8 term dropped

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } ecenc_in_t;

    typedef struct packed {
        logic [7:0] ec_byte;
        logic       last_ec;
    } ecenc_out_t;

    typedef struct packed {
        logic coef_init;
        logic coef_step;
        logic feed;
        logic load;
        logic clear;
        logic shift;
    } ecenc_ctrl_t;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_BUILD,
        ST_RUN
    } ecenc_state_t;

    function automatic logic [7:0] gf_xtime(logic [7:0] a);
        gf_xtime = {a[6:0], 1'b0} ^ (a[7] ? FIELD_LOW : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(logic [7:0] x, logic [7:0] y);
        logic [7:0] a;
        logic [7:0] r;
        a = x;
        r = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (y[k]) begin
                r = r ^ a;
            end
            a = gf_xtime(a);
        end
        gf_mul = r;
    endfunction

    // zero means one, anything above the chain length saturates
    function automatic logic [CNT_W-1:0] ecenc_eff(logic [5:0] v);
        logic [6:0] w;
        logic [6:0] e;
        w = {1'b0, v};
        if (w == 7'd0) begin
            e = 7'd1;
        end else if (w > 7'(MAX_EC)) begin
            e = 7'(MAX_EC);
        end else begin
            e = w;
        end
        ecenc_eff = CNT_W'(e);
    endfunction

endpackage

// ----- rtl/ecenc_cell.sv -----
module ecenc_cell
    import ecenc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  ecenc_ctrl_t ctrl,
    input  logic [7:0]  mul_op,
    input  logic        init_one,
    input  logic [7:0]  coef_up,
    input  logic [7:0]  rem_up,
    input  logic [7:0]  shd_up,
    output logic [7:0]  coef,
    output logic [7:0]  rem,
    output logic [7:0]  shd
);

    logic [7:0] coef_reg;
    logic [7:0] rem_reg;
    logic [7:0] shd_reg;
    logic [7:0] prod;
    logic [7:0] rem_next;

    // one multiplier, shared by generator build and division
    assign prod     = gf_mul(mul_op, coef_reg);
    assign rem_next = rem_up ^ prod;

    always_ff @(posedge aclk) begin
        if (ctrl.coef_init) begin
            coef_reg <= {7'd0, init_one};
        end else if (ctrl.coef_step) begin
            coef_reg <= coef_up ^ prod;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= 8'h00;
        end else if (ctrl.clear) begin
            rem_reg <= 8'h00;
        end else if (ctrl.feed) begin
            rem_reg <= ctrl.load ? 8'h00 : rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            shd_reg <= rem_next;
        end else if (ctrl.shift) begin
            shd_reg <= shd_up;
        end
    end

    assign coef = coef_reg;
    assign rem  = rem_reg;
    assign shd  = shd_reg;

endmodule

// ----- rtl/reed_solomon_ec_encoder.sv -----
// check bytes start the cycle after the last byte is taken, one per cycle if m_ready
// throughput: one message byte per cycle; a last byte waits while earlier check bytes drain
// the generator, of degree n, is rebuilt by the cell chain after reset or a write to
// ec_count, n being ec_count with zero read as one and saturated at 32; no input meanwhile
// reset: synchronous active-low aresetn, ec_count back to 10 and remainder cleared
module reed_solomon_ec_encoder
    import ecenc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [5:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  ecenc_in_t  s_payload,
    output logic       m_valid,
    input  logic       m_ready,
    output ecenc_out_t m_payload
);

    ecenc_state_t     state_reg, state_next;
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] n_dec;
    logic [IDX_W-1:0] n_m1;
    logic [7:0]       root_reg, root_next;
    logic [IDX_W-1:0] build_cnt_reg, build_cnt_next;
    logic             out_busy_reg, out_busy_next;
    logic [IDX_W-1:0] out_cnt_reg, out_cnt_next;
    ecenc_ctrl_t      ctrl;
    logic [7:0]       fb;
    logic [7:0]       mul_op;
    logic             in_xfer;
    logic             out_xfer;

    logic [7:0] coef_w [0:MAX_EC];
    logic [7:0] rem_w  [0:MAX_EC];
    logic [7:0] shd_w  [0:MAX_EC];

    assign n_dec = n_reg - 1'b1;
    assign n_m1  = n_dec[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg <= ecenc_eff(6'd10);
        end else if (cfg_we) begin
            n_reg <= ecenc_eff(cfg_wdata);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            build_cnt_reg <= '0;
            out_busy_reg  <= 1'b0;
            out_cnt_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            build_cnt_reg <= build_cnt_next;
            out_busy_reg  <= out_busy_next;
            out_cnt_reg   <= out_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        root_reg <= root_next;
    end

    assign s_ready  = (state_reg == ST_RUN) && !(out_busy_reg && s_payload.end_of_message);
    assign in_xfer  = s_valid && s_ready;
    assign m_valid  = out_busy_reg;
    assign out_xfer = m_valid && m_ready;
    assign fb       = s_payload.data_byte ^ rem_w[0];
    assign mul_op   = (state_reg == ST_BUILD) ? root_reg : fb;

    always_comb begin
        state_next     = state_reg;
        root_next      = root_reg;
        build_cnt_next = build_cnt_reg;
        ctrl           = '0;
        case (state_reg)
            ST_INIT: begin
                ctrl.coef_init = 1'b1;
                root_next      = 8'h01;
                build_cnt_next = '0;
                state_next     = ST_BUILD;
            end
            ST_BUILD: begin
                // multiply the partial generator by (x + root)
                ctrl.coef_step = 1'b1;
                root_next      = gf_xtime(root_reg);
                build_cnt_next = build_cnt_reg + 1'b1;
                if (build_cnt_reg == n_m1) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                ctrl.feed = in_xfer;
                ctrl.load = in_xfer && s_payload.end_of_message;
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
        ctrl.shift = out_xfer;
        if (cfg_we) begin
            ctrl.clear = 1'b1;
            state_next = ST_INIT;
        end
    end

    always_comb begin
        out_busy_next = out_busy_reg;
        out_cnt_next  = out_cnt_reg;
        if (ctrl.load) begin
            out_busy_next = 1'b1;
            out_cnt_next  = '0;
        end else if (out_xfer) begin
            out_cnt_next = out_cnt_reg + 1'b1;
            if (out_cnt_reg == n_m1) begin
                out_busy_next = 1'b0;
            end
        end
    end

    // cells above the generator degree hold zero coefficients and a zero remainder
    assign coef_w[MAX_EC] = 8'h00;
    assign rem_w[MAX_EC]  = 8'h00;
    assign shd_w[MAX_EC]  = 8'h00;

    for (genvar k = 0; k < MAX_EC; k++) begin : g_cell
        ecenc_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .mul_op   (mul_op),
            .init_one (n_m1 == IDX_W'(k)),
            .coef_up  (coef_w[k+1]),
            .rem_up   (rem_w[k+1]),
            .shd_up   (shd_w[k+1]),
            .coef     (coef_w[k]),
            .rem      (rem_w[k]),
            .shd      (shd_w[k])
        );
    end

    assign m_payload.ec_byte = shd_w[0];
    assign m_payload.last_ec = (out_cnt_reg == n_m1);

    a_no_load_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_payload.end_of_message) |-> !out_busy_reg)
        else $error("last byte taken while check bytes still pending");

    a_load_starts_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_payload.end_of_message) |=> (m_valid && out_cnt_reg == '0))
        else $error("check bytes not presented after last byte");

    a_last_ends_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_payload.last_ec) |=> !m_valid)
        else $error("output still valid after final check byte transfer");

    a_build_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BUILD) |-> (build_cnt_reg <= n_m1))
        else $error("generator build ran past its degree");

    a_no_input_during_build: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_RUN) |-> !s_ready)
        else $error("input taken before generator is ready");

endmodule
